FILE: rtl/core/bfla_pkg.sv
// Shared types and constants of the block free-list allocator.
package bfla_pkg;

    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;

    // Operation codes carried in the mode field of an input item.
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORMAT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

    // Status codes carried in a result item.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CORRUPT  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] block_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  given_block;
        logic [FREE_W-1:0]   free_count;
        logic                last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the accepted item
        logic emit_imm;    // single result decided from the latched item
        logic sweep_init;  // restart the store sweep at entry zero
        logic sweep_step;  // write one entry of both stores
        logic fmt_done;    // sweep complete: refill count and report
        logic pop_rd;      // read the stack top and shrink the stack
        logic pop_wr;      // mark the popped block and report it
        logic rel_rd;      // read the occupied flag of the released block
        logic rel_wr;      // check, push back and report
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              alloc_go;
        logic              sweep_last;
        logic              pop_last;
    } t_dp_stat;

endpackage

FILE: rtl/core/block_free_list_allocator.sv
// Top level of the block free-list allocator: controller plus datapath.
//
// An input item is taken at a rising edge where start is high and busy is
// low. It carries a mode (allocate, release, format, query), a block count
// for allocation and a block index for release. Results appear on o_result
// for exactly one cycle, marked by o_strobe; the receiver cannot hold them
// off, so every result must be captured in its strobe cycle. The final
// result of an item has its last bit set.
// After the accept edge the item is decoded. A query, an overflow or a
// zero-count allocation is reported straight after decode; a release
// reads the occupied flag and then pushes and reports; an allocation of
// n blocks then, for each block, reads the stack top and then writes the
// flag and reports the block, and busy drops with the last result.
// Format rewrites every entry of the free stack and the occupied flags, one
// entry per cycle, and then reports. The memories are single-port: one
// stack access and one flag access a cycle.
// After reset the same sweep runs with busy high and gives no result;
// items are taken once busy falls.
module block_free_list_allocator #(
    parameter int NUM_BLOCKS = 1024,
    parameter int MAX_BATCH  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bfla_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output bfla_pkg::t_out_item o_result
);

    bfla_pkg::t_dp_cmd  dp_cmd;
    bfla_pkg::t_dp_stat dp_stat;

    // The controller sequences each operation; it sees only start and the datapath's status.
    bfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds both memories, the stack depth and the result register.
    bfla_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_BATCH  (MAX_BATCH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: rtl/core/bfla_dp.sv
// Datapath of the block allocator: free stack, occupied flags, counters and result register.
module bfla_dp #(
    parameter int NUM_BLOCKS = 1024,
    parameter int MAX_BATCH  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfla_pkg::t_in_item  i_item,
    input  bfla_pkg::t_dp_cmd   i_cmd,
    output bfla_pkg::t_dp_stat  o_stat,
    output logic                o_strobe,
    output bfla_pkg::t_out_item o_result
);

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    logic [BW-1:0] r_stack_mem [NUM_BLOCKS];
    logic          r_occ_mem   [NUM_BLOCKS];

    logic [bfla_pkg::MODE_W-1:0]  r_mode;
    logic [bfla_pkg::COUNT_W-1:0] r_count;
    logic [bfla_pkg::INDEX_W-1:0] r_blk;
    logic [bfla_pkg::COUNT_W-1:0] r_left;
    logic [CW-1:0]                r_sc;
    logic [BW-1:0]                r_sweep;
    logic [BW-1:0]                r_stk_q;
    logic                         r_occ_q;
    logic                         r_strobe;
    bfla_pkg::t_out_item          r_result;

    logic          count_ok;
    logic          rel_ok;
    logic [31:0]   blk_ext;
    logic [BW-1:0] blk_addr;
    logic [CW-1:0] sc_dec;
    logic [CW-1:0] sc_inc;
    logic [BW-1:0] pop_addr;
    logic [BW-1:0] push_addr;

    assign blk_ext   = 32'(r_blk);
    assign blk_addr  = blk_ext[BW-1:0];
    assign sc_dec    = r_sc - CW'(1);
    assign sc_inc    = r_sc + CW'(1);
    assign pop_addr  = sc_dec[BW-1:0];
    assign push_addr = r_sc[BW-1:0];

    // Strictly more free blocks than asked for keeps block 0 on the stack.
    assign count_ok = (32'(r_count) <= 32'(MAX_BATCH)) && (32'(r_sc) > 32'(r_count));
    assign rel_ok   = (r_blk != '0) && (blk_ext < 32'(NUM_BLOCKS)) && r_occ_q
                      && (32'(r_sc) < 32'(NUM_BLOCKS));

    assign o_stat.mode       = r_mode;
    assign o_stat.alloc_go   = count_ok && (r_count != '0);
    assign o_stat.sweep_last = (r_sweep == BW'(NUM_BLOCKS - 1));
    assign o_stat.pop_last   = (r_left == bfla_pkg::COUNT_W'(1));

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Free stack memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step) begin
            r_stack_mem[r_sweep] <= r_sweep;
        end else if (i_cmd.rel_wr && rel_ok) begin
            r_stack_mem[push_addr] <= blk_addr;
        end
        if (i_cmd.pop_rd) begin
            r_stk_q <= r_stack_mem[pop_addr];
        end
    end

    // Occupied flag memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step) begin
            r_occ_mem[r_sweep] <= 1'b0;
        end else if (i_cmd.pop_wr) begin
            r_occ_mem[r_stk_q] <= 1'b1;
        end else if (i_cmd.rel_wr && rel_ok) begin
            r_occ_mem[blk_addr] <= 1'b0;
        end
        if (i_cmd.rel_rd) begin
            r_occ_q <= r_occ_mem[blk_addr];
        end
    end

    // Latched item and pop counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_item.mode;
            r_count <= i_item.count;
            r_blk   <= i_item.block_index;
            r_left  <= i_item.count;
        end else if (i_cmd.pop_wr) begin
            r_left <= r_left - bfla_pkg::COUNT_W'(1);
        end
    end

    // Control state: stack depth and sweep position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= CW'(NUM_BLOCKS);
            r_sweep <= '0;
        end else begin
            if (i_cmd.pop_rd) begin
                r_sc <= sc_dec;
            end else if (i_cmd.rel_wr && rel_ok) begin
                r_sc <= sc_inc;
            end else if (i_cmd.fmt_done) begin
                r_sc <= CW'(NUM_BLOCKS);
            end
            if (i_cmd.sweep_init) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + BW'(1);
            end
        end
    end

    // Result register: one strobe cycle per result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_imm || i_cmd.pop_wr || i_cmd.rel_wr || i_cmd.fmt_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_imm) begin
            r_result.status      <= ((r_mode == bfla_pkg::MODE_ALLOC) && !count_ok)
                                    ? bfla_pkg::ST_OVERFLOW : bfla_pkg::ST_OK;
            r_result.given_block <= '0;
            r_result.free_count  <= bfla_pkg::FREE_W'(r_sc);
            r_result.last        <= 1'b1;
        end else if (i_cmd.pop_wr) begin
            r_result.status      <= bfla_pkg::ST_OK;
            r_result.given_block <= bfla_pkg::INDEX_W'(r_stk_q);
            r_result.free_count  <= bfla_pkg::FREE_W'(r_sc);
            r_result.last        <= o_stat.pop_last;
        end else if (i_cmd.rel_wr) begin
            r_result.status      <= rel_ok ? bfla_pkg::ST_OK : bfla_pkg::ST_CORRUPT;
            r_result.given_block <= '0;
            r_result.free_count  <= rel_ok ? bfla_pkg::FREE_W'(sc_inc)
                                           : bfla_pkg::FREE_W'(r_sc);
            r_result.last        <= 1'b1;
        end else if (i_cmd.fmt_done) begin
            r_result.status      <= bfla_pkg::ST_OK;
            r_result.given_block <= '0;
            r_result.free_count  <= bfla_pkg::FREE_W'(NUM_BLOCKS);
            r_result.last        <= 1'b1;
        end
    end

endmodule

FILE: rtl/core/bfla_ctrl.sv
// Controller state machine of the block allocator.
module bfla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bfla_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output bfla_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_INIT     = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DISPATCH = 8'b0000_0100,
        S_POP_RD   = 8'b0000_1000,
        S_POP_WR   = 8'b0001_0000,
        S_REL_RD   = 8'b0010_0000,
        S_REL_WR   = 8'b0100_0000,
        S_FMT      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.mode)
                    bfla_pkg::MODE_ALLOC: begin
                        if (i_stat.alloc_go) begin
                            n_state = S_POP_RD;
                        end else begin
                            o_cmd.emit_imm = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    bfla_pkg::MODE_RELEASE: begin
                        n_state = S_REL_RD;
                    end
                    bfla_pkg::MODE_FORMAT: begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = S_FMT;
                    end
                    default: begin
                        o_cmd.emit_imm = 1'b1;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.pop_wr = 1'b1;
                n_state      = i_stat.pop_last ? S_IDLE : S_POP_RD;
            end
            S_REL_RD: begin
                o_cmd.rel_rd = 1'b1;
                n_state      = S_REL_WR;
            end
            S_REL_WR: begin
                o_cmd.rel_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_FMT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.fmt_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

FILE: bench/tb_block_free_list_allocator.sv
// Self-checking testbench of the block free-list allocator.
`timescale 1ns / 1ps

module tb_block_free_list_allocator;

    localparam int NUM_BLOCKS = 1024;
    localparam int MAX_BATCH  = 16;
    // The slowest correct run stays far below this, even with every item at
    // 16 blocks and the longest gaps, since formats are capped.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_FORMATS = 12;

    // Tracks the free stack and the occupied flags as the block should hold
    // them. Every accepted item is turned into its expected results, and each
    // strobed result is checked against the oldest one still waiting.
    class free_list_tracker;
        logic [bfla_pkg::INDEX_W-1:0] stack_mem[NUM_BLOCKS];
        logic [bfla_pkg::FREE_W-1:0]  free_cnt;
        bit                           in_use[NUM_BLOCKS];
        // Blocks that are handed out, so that the stimulus can free them.
        logic [bfla_pkg::INDEX_W-1:0] held[$];
        bfla_pkg::t_out_item          expected_results[$];
        int                           errors;

        function new();
            errors = 0;
            format_store();
        endfunction

        function void format_store();
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                stack_mem[i] = bfla_pkg::INDEX_W'(i);
                in_use[i] = 1'b0;
            end
            free_cnt = bfla_pkg::FREE_W'(NUM_BLOCKS);
            held.delete();
        endfunction

        function void expect_result(logic [bfla_pkg::STATUS_W-1:0] status,
                                    logic [bfla_pkg::INDEX_W-1:0] blk, logic last);
            bfla_pkg::t_out_item r;
            r.status      = status;
            r.given_block = blk;
            r.free_count  = free_cnt;
            r.last        = last;
            expected_results = {expected_results, r};
        endfunction

        function void note_item(bfla_pkg::t_in_item it);
            logic [bfla_pkg::INDEX_W-1:0] blk;
            case (it.mode)
                bfla_pkg::MODE_ALLOC: begin
                    // The strict compare keeps block 0 at the bottom forever.
                    if (it.count > MAX_BATCH || free_cnt <= it.count) begin
                        expect_result(bfla_pkg::ST_OVERFLOW, '0, 1'b1);
                    end else if (it.count == 0) begin
                        expect_result(bfla_pkg::ST_OK, '0, 1'b1);
                    end else begin
                        for (int k = 0; k < it.count; k++) begin
                            free_cnt = free_cnt - 1'b1;
                            blk = stack_mem[free_cnt];
                            in_use[blk] = 1'b1;
                            held = {held, blk};
                            expect_result(bfla_pkg::ST_OK, blk, k == it.count - 1);
                        end
                    end
                end
                bfla_pkg::MODE_RELEASE: begin
                    blk = it.block_index;
                    if (blk == 0 || blk >= NUM_BLOCKS || !in_use[blk] ||
                        free_cnt >= NUM_BLOCKS) begin
                        expect_result(bfla_pkg::ST_CORRUPT, '0, 1'b1);
                    end else begin
                        in_use[blk] = 1'b0;
                        stack_mem[free_cnt] = blk;
                        free_cnt = free_cnt + 1'b1;
                        for (int i = 0; i < held.size(); i++) begin
                            if (held[i] == blk) begin
                                held.delete(i);
                                break;
                            end
                        end
                        expect_result(bfla_pkg::ST_OK, '0, 1'b1);
                    end
                end
                bfla_pkg::MODE_FORMAT: begin
                    format_store();
                    expect_result(bfla_pkg::ST_OK, '0, 1'b1);
                end
                default: begin
                    expect_result(bfla_pkg::ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(bfla_pkg::t_out_item got);
            bfla_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d block %0d free %0d last %0d",
                         $time, got.status, got.given_block, got.free_count, got.last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("status", want.status, got.status);
            compare("given_block", want.given_block, got.given_block);
            compare("free_count", want.free_count, got.free_count);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    bfla_pkg::t_in_item  i_item;
    logic                o_strobe;
    bfla_pkg::t_out_item o_result;

    free_list_tracker sb;
    int  cycle_count = 0;
    // While set, items follow each other with no idle cycle in between.
    bit  no_idle = 1'b0;

    block_free_list_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .MAX_BATCH (MAX_BATCH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is checked in its own cycle.
    // Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_result);
        end
    end

    // Presents one item and holds start until an edge with busy low takes it.
    // After that, start either stays high for the next item or drops for a
    // gap whose length is mostly short and now and then long.
    task automatic send_item(input bfla_pkg::t_in_item it);
        int          r;
        int          gap;
        logic [31:0] junk;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        r = $urandom_range(0, 99);
        if (no_idle || r < 45) begin
            gap = 0;
        end else if (r < 85) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 70);
        end
        if (gap > 0) begin
            // Junk on the item bus while start is low must be ignored.
            junk   = $urandom;
            start  <= 1'b0;
            i_item <= junk[$bits(bfla_pkg::t_in_item)-1:0];
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic bfla_pkg::t_in_item make_item(logic [bfla_pkg::MODE_W-1:0] mode,
                                                     int count, int blk);
        bfla_pkg::t_in_item it;
        it.mode        = mode;
        it.count       = bfla_pkg::COUNT_W'(count);
        it.block_index = bfla_pkg::INDEX_W'(blk);
        return it;
    endfunction

    initial begin
        bfla_pkg::t_in_item it;
        int                 r;
        int                 cnt;
        int                 formats;
        bit                 draining;

        sb = new();
        formats = 2;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The clearing sweep after reset keeps busy high,
        // so the first item simply waits for it.
        send_item(make_item(bfla_pkg::MODE_QUERY, 0, 0));
        send_item(make_item(bfla_pkg::MODE_ALLOC, 0, 0));             // zero count
        send_item(make_item(bfla_pkg::MODE_ALLOC, 1, 0));             // top of stack
        send_item(make_item(bfla_pkg::MODE_ALLOC, MAX_BATCH, 0));     // full batch
        send_item(make_item(bfla_pkg::MODE_ALLOC, MAX_BATCH + 1, 0)); // batch too large
        send_item(make_item(bfla_pkg::MODE_ALLOC, 31, 1023));         // all count bits set
        send_item(make_item(bfla_pkg::MODE_RELEASE, 0, 0));           // block zero
        send_item(make_item(bfla_pkg::MODE_RELEASE, 0, 1023));        // held, so freed
        send_item(make_item(bfla_pkg::MODE_RELEASE, 31, 1023));       // freed twice
        send_item(make_item(bfla_pkg::MODE_RELEASE, 0, 5));           // never handed out
        send_item(make_item(bfla_pkg::MODE_RELEASE, 0, 1009));
        send_item(make_item(bfla_pkg::MODE_ALLOC, 2, 0));             // pops the freed ones
        send_item(make_item(bfla_pkg::MODE_QUERY, 31, 1023));
        send_item(make_item(bfla_pkg::MODE_FORMAT, 0, 0));
        send_item(make_item(bfla_pkg::MODE_RELEASE, 0, 1010));        // cleared by format
        send_item(make_item(bfla_pkg::MODE_QUERY, 0, 0));

        // Random part. Fill stretches run the stack down to its last free
        // blocks so that the overflow edge is hit; drain stretches hand the
        // held blocks back. Some releases are noise over the whole range.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            draining = ((n / 60) % 2) == 1;
            r = $urandom_range(0, 99);
            if (r < 3 && formats < MAX_FORMATS) begin
                formats++;
                it = make_item(bfla_pkg::MODE_FORMAT, $urandom_range(0, 31),
                               $urandom_range(0, 1023));
            end else if (r < 12) begin
                it = make_item(bfla_pkg::MODE_QUERY, $urandom_range(0, 31),
                               $urandom_range(0, 1023));
            end else if ((!draining && r < 75) || (draining && r < 32)) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    cnt = $urandom_range(0, 31);
                end else if (sb.free_cnt <= MAX_BATCH + 1 && r < 55) begin
                    // Either the whole free count, which overflows, or one less, which just fits.
                    cnt = sb.free_cnt - $urandom_range(0, 1);
                end else if (draining) begin
                    cnt = $urandom_range(1, 4);
                end else begin
                    cnt = $urandom_range(1, MAX_BATCH);
                end
                it = make_item(bfla_pkg::MODE_ALLOC, cnt, $urandom_range(0, 1023));
            end else begin
                if (sb.held.size() > 0 && $urandom_range(0, 99) < 75) begin
                    cnt = sb.held[$urandom_range(0, sb.held.size() - 1)];
                end else begin
                    cnt = $urandom_range(0, 1023);
                end
                it = make_item(bfla_pkg::MODE_RELEASE, $urandom_range(0, 31), cnt);
            end
            send_item(it);
        end
        start <= 1'b0;

        // Every item ends with a result, so an empty queue means the block
        // is idle; a short wait then catches any stray extra result.
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
